FILE: src/u8f_pkg.sv
// ----------------------------------------------------------------------------
// u8f_pkg: shared types and constants for the UTF-8 orphan byte filter
// Holds the byte class limits and the command record that the front stage
// queues for the back stage.
// ----------------------------------------------------------------------------
`default_nettype none

package u8f_pkg;

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD2_LOW  = 8'hC0;
    localparam logic [7:0] LEAD3_LOW  = 8'hE0;
    localparam logic [7:0] LEAD4_LOW  = 8'hF0;
    localparam logic [7:0] LEAD_LIMIT = 8'hF5;
    localparam logic [7:0] ASCII_LIM  = 8'h80;

    localparam int unsigned MAX_BYTES = 4;
    localparam int unsigned QDEPTH    = 4;
    localparam int unsigned QPTR_W    = $clog2(QDEPTH);
    localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

    // One queued command: one to four result items from a single input item.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [1:0]                last_idx;   // index of the final result item
        logic                      byte_valid; // 0 only for a bare end marker
        logic                      end_of_run;
    } t_cmd;

endpackage

`default_nettype wire

FILE: src/u8f_front.sv
// ----------------------------------------------------------------------------
// u8f_front: classify input items and track the pending sequence
// Decides on each accepted item which bytes are released and forms one
// queue command when there is anything to emit.
// ----------------------------------------------------------------------------
`default_nettype none

module u8f_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_last_byte,
    output u8f_pkg::t_cmd      o_cmd,
    output logic               o_push
);

    logic [2:0][7:0] r_held;
    logic [1:0]      r_held_cnt;
    logic [1:0]      r_need_cnt;
    logic            r_at_start;

    logic [2:0][7:0] n_held;
    logic [1:0]      n_held_cnt;
    logic [1:0]      n_need_cnt;
    logic            n_at_start;

    logic [3:0][7:0] list;
    logic [2:0]      nres;
    logic            fresh;
    logic            is_cont;

    always_comb begin
        n_held     = r_held;
        n_held_cnt = r_held_cnt;
        n_need_cnt = r_need_cnt;
        n_at_start = r_at_start;
        list       = '0;
        nres       = 3'd0;
        fresh      = 1'b1;
        is_cont    = (i_data_byte & u8f_pkg::CONT_MASK) == u8f_pkg::CONT_CODE;

        if (r_at_start && i_last_byte) begin
            // single-byte stream passes unchanged
            list[0] = i_data_byte;
            nres    = 3'd1;
            fresh   = 1'b0;
        end else begin
            n_at_start = 1'b0;
            if (r_need_cnt != 2'd0) begin
                if (is_cont) begin
                    fresh = 1'b0;
                    if (r_need_cnt == 2'd1) begin
                        for (int i = 0; i < 4; i++) begin
                            if (i < int'(r_held_cnt)) begin
                                list[i] = r_held[i];
                            end else if (i == int'(r_held_cnt)) begin
                                list[i] = i_data_byte;
                            end
                        end
                        nres       = {1'b0, r_held_cnt} + 3'd1;
                        n_held_cnt = 2'd0;
                        n_need_cnt = 2'd0;
                    end else if (r_held_cnt < 2'd3) begin
                        n_held[r_held_cnt] = i_data_byte;
                        n_held_cnt         = r_held_cnt + 2'd1;
                        n_need_cnt         = r_need_cnt - 2'd1;
                    end else begin
                        n_held_cnt = 2'd0;
                        n_need_cnt = 2'd0;
                    end
                end else begin
                    // interrupted sequence: drop held bytes
                    n_held_cnt = 2'd0;
                    n_need_cnt = 2'd0;
                end
            end
            if (fresh) begin
                if (i_data_byte < u8f_pkg::ASCII_LIM) begin
                    list[0] = i_data_byte;
                    nres    = 3'd1;
                end else if (i_data_byte >= u8f_pkg::LEAD2_LOW &&
                             i_data_byte < u8f_pkg::LEAD_LIMIT) begin
                    n_held[0]  = i_data_byte;
                    n_held_cnt = 2'd1;
                    if (i_data_byte < u8f_pkg::LEAD3_LOW) begin
                        n_need_cnt = 2'd1;
                    end else if (i_data_byte < u8f_pkg::LEAD4_LOW) begin
                        n_need_cnt = 2'd2;
                    end else begin
                        n_need_cnt = 2'd3;
                    end
                end
            end
        end

        if (i_last_byte) begin
            n_held_cnt = 2'd0;
            n_need_cnt = 2'd0;
            n_at_start = 1'b1;
        end
    end

    always_comb begin
        o_cmd.bytes      = list;
        o_cmd.byte_valid = (nres != 3'd0);
        o_cmd.end_of_run = i_last_byte;
        o_cmd.last_idx   = (nres == 3'd0) ? 2'd0 : 2'(nres - 3'd1);
        o_push           = i_accept && ((nres != 3'd0) || i_last_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= 2'd0;
            r_need_cnt <= 2'd0;
            r_at_start <= 1'b1;
        end else if (i_accept) begin
            r_held_cnt <= n_held_cnt;
            r_need_cnt <= n_need_cnt;
            r_at_start <= n_at_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held <= n_held;
        end
    end

endmodule

`default_nettype wire

FILE: src/u8f_queue.sv
// ----------------------------------------------------------------------------
// u8f_queue: command queue between front and back stages
// Small circular buffer; full stalls the front, empty idles the back.
// ----------------------------------------------------------------------------
`default_nettype none

module u8f_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire u8f_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output u8f_pkg::t_cmd      o_head,
    output logic               o_head_valid,
    output logic               o_full
);

    u8f_pkg::t_cmd r_mem [u8f_pkg::QDEPTH];
    logic [u8f_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [u8f_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [u8f_pkg::QCNT_W-1:0] r_count;

    logic do_pop;

    assign do_pop       = i_pop && (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign o_head_valid = (r_count != '0);
    assign o_full       = (r_count == u8f_pkg::QCNT_W'(u8f_pkg::QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/u8f_back.sv
// ----------------------------------------------------------------------------
// u8f_back: serialize queued commands into result items
// Steps through the bytes of the head command into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module u8f_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire u8f_pkg::t_cmd i_head,
    input  wire logic          i_head_valid,
    output logic               o_pop,
    input  wire logic          i_stall,
    output logic               o_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_byte_valid,
    output logic               o_end_of_run
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_bval;
    logic       r_eor;

    logic load;
    logic is_final;

    assign is_final = (r_idx == i_head.last_idx);
    assign load     = i_head_valid && (!r_valid || !i_stall);
    assign o_pop    = load && is_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= is_final ? 2'd0 : r_idx + 2'd1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // hold payload while stalled
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_head.bytes[r_idx];
            r_bval <= i_head.byte_valid;
            r_eor  <= i_head.end_of_run && is_final;
        end
    end

    assign o_valid      = r_valid;
    assign o_out_byte   = r_byte;
    assign o_byte_valid = r_bval;
    assign o_end_of_run = r_eor;

endmodule

`default_nettype wire

FILE: src/utf8_orphan_byte_filter_unit.sv
// ----------------------------------------------------------------------------
// utf8_orphan_byte_filter_unit: UTF-8 sanitizer for a byte stream
// Flow: accepted items are queued as commands; the back stage steps each one
//   into the output register. Throughput: one input item per cycle unless the
//   four-entry command queue is full; a k-byte sequence leaves as k items.
// Reset: synchronous, active low; clears sequence state, queue and output.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_orphan_byte_filter_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_valid,
    output logic            o_end_of_run
);

    // Front: the sequence tracker. It decides, per input item, which bytes
    // come out and pushes them as one command. Stall only when the queue
    // is full, so the input side never waits on the output side directly.
    u8f_pkg::t_cmd  front_cmd;
    u8f_pkg::t_cmd  head_cmd;
    logic           head_valid;
    logic           pop;
    logic           push;
    logic           q_full;
    logic           in_accept;

    assign in_accept = i_valid && !o_stall;
    assign o_stall   = q_full;

    u8f_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_cmd       (front_cmd),
        .o_push      (push)
    );

    // Queue: decouples bursts of up to four result items from the input, which
    // takes one byte per cycle while the queue is not full.
    u8f_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (front_cmd),
        .i_pop        (pop),
        .o_head       (head_cmd),
        .o_head_valid (head_valid),
        .o_full       (q_full)
    );

    // Back: serializes the head command into registered result items.
    u8f_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_cmd),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_end_of_run (o_end_of_run)
    );

endmodule

`default_nettype wire

FILE: src/u8f_checker.sv
// ----------------------------------------------------------------------------
// u8f_checker: port-level assertions for the UTF-8 filter
// Watches the top level's ports only; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module u8f_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_byte_valid,
    input wire logic       o_end_of_run
);

    // stalled result item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) &&
        $stable(o_byte_valid) && $stable(o_end_of_run))
        else $error("stalled result item changed");

    // a bare end marker carries zero and closes the run
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid |-> o_end_of_run && (o_out_byte == 8'h00))
        else $error("bad bare end marker");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // reset empties the queue, so input is not stalled
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");

endmodule

bind utf8_orphan_byte_filter_unit u8f_checker u_u8f_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_out_byte   (o_out_byte),
    .o_byte_valid (o_byte_valid),
    .o_end_of_run (o_end_of_run)
);

`default_nettype wire
